### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Clock is clk_i, reset is rst_ni (active low); checks are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge out of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a rising edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/updc_pkg.sv
package updc_pkg;

  localparam logic [7:0] ChPercent   = 8'h25;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [3:0] HexLetterBase = 4'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Hex digit decode, either case.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        diff    = c - ChZero;
        r.ok    = 1'b1;
        r.value = diff[3:0];
      end
      [8'h61:8'h66]: begin
        diff    = c - ChLowerA;
        r.ok    = 1'b1;
        r.value = diff[3:0] + HexLetterBase;
      end
      [8'h41:8'h46]: begin
        diff    = c - ChUpperA;
        r.ok    = 1'b1;
        r.value = diff[3:0] + HexLetterBase;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/url_path_decode_and_check.sv
// Request path percent-decoder and checker.
// Input channel: one raw path byte per transfer (in_byte_i), last_i on the
// final byte; in_valid_i / in_ready_o.
// Output channel: out_valid_o / out_ready_i. A result carries a decoded byte
// (byte_valid_o) and/or the verdict (path_end_o, path_ok_o) for the final byte.
// Bytes that complete nothing ('%' and the first hex digit of an escape) and
// all bytes after a rejection give no result, except the final one.
// A byte taken sits in the input register, is decoded and checked there,
// and moves into the result register once that one is free or being read.
// Throughput: one byte per cycle unless the receiver stalls; the only state is
// a handful of small registers updated by one short decode/compare step.
// Receiver stall: the result register holds; the input register fills and
// then in_ready_o drops. in_ready_o follows out_ready_i combinationally.
// Reset: both registers empty and the path state at its initial values.
// After the final byte the path state returns to those values by itself.
module url_path_decode_and_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       path_end_o,
  output logic       path_ok_o
);
  import updc_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,  // after '%'
    ESC_LOW  = 2'd2   // after first hex digit
  } esc_phase_e;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Path state
  logic [1:0] bytes_seen_q, bytes_seen_d;
  esc_phase_e esc_q, esc_d;
  logic [3:0] nibble_q, nibble_d;
  logic [1:0] seg_len_q, seg_len_d;
  logic       seg_dots_q, seg_dots_d;
  logic       failed_q, failed_d;

  // Result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       byte_valid_q, byte_valid_d;
  logic       path_end_q, path_end_d;
  logic       path_ok_q, path_ok_d;

  logic       adv;      // input register moves into result register
  logic       first;
  logic       have;
  logic       emit;
  logic [7:0] val;
  hex_t       hex;
  logic       seg_bad_now;
  logic       seg_bad_end;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  assign hex         = hex_decode(s1_byte_q);
  assign first       = (bytes_seen_q == 2'd0);
  // Segment empty, "." or ".." (length saturates at 3)
  assign seg_bad_now = (seg_len_q == 2'd0) || ((seg_len_q != 2'd3) && seg_dots_q);

  always_comb begin
    bytes_seen_d = (bytes_seen_q == 2'd2) ? bytes_seen_q : bytes_seen_q + 2'd1;
    esc_d        = esc_q;
    nibble_d     = nibble_q;
    seg_len_d    = seg_len_q;
    seg_dots_d   = seg_dots_q;
    failed_d     = failed_q;
    have         = 1'b0;
    emit         = 1'b0;
    val          = '0;
    seg_bad_end  = 1'b0;

    if (!failed_q) begin
      if (first) begin
        // First byte never opens an escape and begins no segment
        if (s1_byte_q == ChSlash) begin
          emit = 1'b1;
          val  = s1_byte_q;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        case (esc_q)
          ESC_HIGH: begin
            if (hex.ok) begin
              nibble_d = hex.value;
              esc_d    = ESC_LOW;
            end else begin
              failed_d = 1'b1;
            end
          end
          ESC_LOW: begin
            if (hex.ok) begin
              val   = {nibble_q, hex.value};
              have  = 1'b1;
              esc_d = ESC_NONE;
            end else begin
              failed_d = 1'b1;
            end
          end
          default: begin
            if (s1_byte_q == ChPercent) begin
              esc_d = ESC_HIGH;
            end else begin
              val  = s1_byte_q;
              have = 1'b1;
            end
          end
        endcase
      end

      if (have) begin
        if (val == ChNul || val == ChBackslash || val == ChColon) begin
          failed_d = 1'b1;
        end else if (val == ChSlash) begin
          // Raw or decoded separator closes the segment
          if (seg_bad_now) begin
            failed_d = 1'b1;
          end else begin
            seg_len_d  = 2'd0;
            seg_dots_d = 1'b1;
            emit       = 1'b1;
          end
        end else begin
          if (seg_len_q != 2'd3) seg_len_d = seg_len_q + 2'd1;
          if (val != ChDot) seg_dots_d = 1'b0;
          emit = 1'b1;
        end
      end
    end

    out_valid_d  = emit || s1_last_q;
    out_byte_d   = emit ? val : 8'h00;
    byte_valid_d = emit;
    path_end_d   = s1_last_q;
    path_ok_d    = 1'b0;

    if (s1_last_q) begin
      // End checks: open escape, short path, bad final segment
      seg_bad_end = (seg_len_d == 2'd0) || ((seg_len_d != 2'd3) && seg_dots_d);
      if (!failed_d && (esc_d != ESC_NONE || bytes_seen_d != 2'd2 || seg_bad_end)) begin
        failed_d = 1'b1;
      end
      path_ok_d    = !failed_d;
      bytes_seen_d = 2'd0;
      esc_d        = ESC_NONE;
      nibble_d     = 4'd0;
      seg_len_d    = 2'd0;
      seg_dots_d   = 1'b1;
      failed_d     = 1'b0;
    end
  end

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      bytes_seen_q <= 2'd0;
      esc_q        <= ESC_NONE;
      nibble_q     <= 4'd0;
      seg_len_q    <= 2'd0;
      seg_dots_q   <= 1'b1;
      failed_q     <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (adv) begin
        out_valid_q  <= out_valid_d;
        bytes_seen_q <= bytes_seen_d;
        esc_q        <= esc_d;
        nibble_q     <= nibble_d;
        seg_len_q    <= seg_len_d;
        seg_dots_q   <= seg_dots_d;
        failed_q     <= failed_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= last_i;
    end
    if (adv) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      path_end_q   <= path_end_d;
      path_ok_q    <= path_ok_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign path_end_o   = path_end_q;
  assign path_ok_o    = path_ok_q;

  `ASSERT_NEVER(a_no_bad_byte, out_valid_o && byte_valid_o && (out_byte_o == ChNul || out_byte_o == ChBackslash || out_byte_o == ChColon), "forbidden byte emitted")
  `ASSERT_PROP(a_no_empty_result, out_valid_o |-> (byte_valid_o || path_end_o), "empty result")
  `ASSERT_PROP(a_ok_only_at_end, (out_valid_o && path_ok_o) |-> path_end_o, "verdict outside path end")
  `ASSERT_PROP(a_silent_after_fail, (adv && failed_q) |=> !byte_valid_o, "byte emitted after failure")
  `ASSERT_PROP(a_clear_at_end, (adv && s1_last_q) |=> (bytes_seen_q == 2'd0 && !failed_q && esc_q == ESC_NONE), "state not cleared after last byte")

endmodule

### verif/tb_url_path_decode_and_check.sv
`timescale 1ns / 100ps

module tb_url_path_decode_and_check;
  import updc_pkg::*;

  // Escape decode progress: none, after '%', after the first hex digit.
  typedef enum logic [1:0] {
    EscNone,
    EscHigh,
    EscLow
  } esc_state_e;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       path_end;
    logic       path_ok;
  } path_result_t;

  localparam int HalfPeriod = 6;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = '0;
  logic       last_i      = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       path_end_o;
  logic       path_ok_o;

  // Predictor state, one copy of the block's per-path registers.
  logic [1:0] seen_cnt;
  esc_state_e esc_state;
  logic [3:0] esc_hi;
  logic [1:0] seg_len;
  logic       seg_dots;
  logic       path_rejected;

  path_result_t decoded_q[$];  // results still owed by the block, oldest first
  logic [7:0]   path_q[$];     // raw bytes of the path about to be sent

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_bytes     = 0;
  int fail_cnt       = 0;

  url_path_decode_and_check u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .path_end_o  (path_end_o),
    .path_ok_o   (path_ok_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Receiver: ready redrawn every cycle against the current stall rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void clear_path_state();
    seen_cnt      = 2'd0;
    esc_state     = EscNone;
    esc_hi        = 4'd0;
    seg_len       = 2'd0;
    seg_dots      = 1'b1;
    path_rejected = 1'b0;
  endfunction

  // Hex digit of either case; returns 0 for anything else.
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    v = '0;
    if (c >= ChZero && c <= ChZero + 8'd9) begin
      d = c - ChZero;
    end else if (c >= ChLowerA && c <= ChLowerA + 8'd5) begin
      d = c - ChLowerA + 8'(HexLetterBase);
    end else if (c >= ChUpperA && c <= ChUpperA + 8'd5) begin
      d = c - ChUpperA + 8'(HexLetterBase);
    end else begin
      return 1'b0;
    end
    v = d[3:0];
    return 1'b1;
  endfunction

  // Empty, "." or ".." (length saturates at 3, so longer dot runs pass).
  function automatic logic segment_bad();
    return (seg_len == 2'd0) || (seg_len <= 2'd2 && seg_dots);
  endfunction

  // Advance the predicted state by one accepted raw byte and queue the
  // result it owes, if any.
  function automatic void decode_path_byte(input logic [7:0] b, input logic l);
    path_result_t r;
    logic         first;
    logic         have;
    logic         emit;
    logic [7:0]   val;
    logic [3:0]   nib;
    first = (seen_cnt == 2'd0);
    have  = 1'b0;
    emit  = 1'b0;
    val   = '0;
    if (seen_cnt != 2'd2) seen_cnt++;

    if (!path_rejected) begin
      // The leading byte is never an escape and opens no segment.
      if (first) begin
        if (b == ChSlash) begin
          emit = 1'b1;
          val  = b;
        end else begin
          path_rejected = 1'b1;
        end
      end else if (esc_state == EscHigh) begin
        if (hex_nibble(b, nib)) begin
          esc_hi    = nib;
          esc_state = EscLow;
        end else begin
          path_rejected = 1'b1;
        end
      end else if (esc_state == EscLow) begin
        if (hex_nibble(b, nib)) begin
          val       = {esc_hi, nib};
          have      = 1'b1;
          esc_state = EscNone;
        end else begin
          path_rejected = 1'b1;
        end
      end else if (b == ChPercent) begin
        esc_state = EscHigh;
      end else begin
        val  = b;
        have = 1'b1;
      end

      // A decoded byte that trips a rejection is itself withheld.
      if (have) begin
        if (val == ChNul || val == ChBackslash || val == ChColon) begin
          path_rejected = 1'b1;
        end else if (val == ChSlash) begin
          if (segment_bad()) begin
            path_rejected = 1'b1;
          end else begin
            seg_len  = 2'd0;
            seg_dots = 1'b1;
            emit     = 1'b1;
          end
        end else begin
          if (seg_len != 2'd3) seg_len++;
          if (val != ChDot) seg_dots = 1'b0;
          emit = 1'b1;
        end
      end
    end

    r.out_byte   = emit ? val : 8'h00;
    r.byte_valid = emit;
    r.path_end   = l;
    r.path_ok    = 1'b0;
    // End-only checks fail the verdict but leave this step's byte standing.
    if (l) begin
      if (!path_rejected &&
          (esc_state != EscNone || seen_cnt != 2'd2 || segment_bad())) begin
        path_rejected = 1'b1;
      end
      r.path_ok = !path_rejected;
      clear_path_state();
    end
    if (l || emit) decoded_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Every output transfer is matched against the oldest owed result.
  always @(posedge clk_i) begin : check_results
    path_result_t want_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h bv %b end %b ok %b",
                 $time, out_byte_o, byte_valid_o, path_end_o, path_ok_o);
        fail_cnt++;
      end else begin
        want_r = decoded_q.pop_front();
        check_field("out_byte", want_r.out_byte, out_byte_o);
        check_field("byte_valid", 8'(want_r.byte_valid), 8'(byte_valid_o));
        check_field("path_end", 8'(want_r.path_end), 8'(path_end_o));
        check_field("path_ok", 8'(want_r.path_ok), 8'(path_ok_o));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // One input transfer. Valid is only dropped for idle cycles, so back-to-back
  // bytes keep it high. Called and returns just after a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    decode_path_byte(b, l);
    sent_bytes++;
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++) begin
      send_byte(path_q[i], i == path_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    path_q.delete();
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
    send_path();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < HexLetterBase) return ChZero + 8'(n);
    return (($urandom_range(1) != 0) ? ChUpperA : ChLowerA) + 8'(n - HexLetterBase);
  endfunction

  function automatic void push_escape(input logic [7:0] v);
    path_q.push_back(ChPercent);
    path_q.push_back(hex_char(v[7:4]));
    path_q.push_back(hex_char(v[3:0]));
  endfunction

  // Printable byte that passes through as itself.
  function automatic logic [7:0] plain_char();
    logic [7:0] v;
    v = 8'($urandom_range(8'h21, 8'h7e));
    if (v == ChPercent || v == ChSlash || v == ChBackslash || v == ChColon) v = ChLowerA;
    return v;
  endfunction

  // Mostly well-formed path: segments of plain bytes, dots and escapes, split
  // by raw or escaped slashes; a quarter get a byte spoiled or added, or cut.
  task automatic build_path();
    int nseg;
    int seglen;
    int pos;
    path_q = {ChSlash};
    nseg   = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if (s != 0) begin
        if ($urandom_range(3) == 0) push_escape(ChSlash);
        else path_q.push_back(ChSlash);
      end
      seglen = $urandom_range(1, 5);
      for (int k = 0; k < seglen; k++) begin
        case ($urandom_range(9))
          0:       path_q.push_back(ChDot);
          1:       push_escape(ChDot);
          2, 3:    push_escape(8'($urandom_range(255)));
          default: path_q.push_back(plain_char());
        endcase
      end
    end
    if ($urandom_range(99) < 25) begin
      pos = $urandom_range(path_q.size() - 1);
      case ($urandom_range(3))
        0:       path_q[pos] = 8'($urandom_range(255));
        1:       while (path_q.size() > pos + 1) void'(path_q.pop_back());
        2:       path_q.insert(pos, ($urandom_range(1) != 0) ? ChSlash : ChPercent);
        default: path_q.insert(pos, ChDot);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Length and leading-byte rules; high raw bytes pass through.
  task automatic test_plain_paths();
    set_idling(0, 0);
    send_text("/a");
    send_text("/");
    send_text("a");
    send_text("x/ab");
    send_text("%41");
    path_q = {ChSlash, 8'hFF, 8'h80};
    send_path();
  endtask

  // Escapes of both cases, escaped separator, cut-off and malformed escapes.
  task automatic test_escapes();
    set_idling(50, 0);
    send_text("/%41%7e");
    send_text("/%fF");
    send_text("/a%2Fb");
    send_text("/%4");
    send_text("/%");
    send_text("/%G1");
    send_text("/%4z");
  endtask

  // NUL, backslash and colon, raw and escaped; failure stops later output.
  task automatic test_forbidden_bytes();
    set_idling(0, 50);
    path_q = {ChSlash, ChLowerA, ChNul, ChLowerA};
    send_path();
    send_text("/%00");
    send_text("/a\\");
    send_text("/a:b/c");
    send_text("/%5c");
    send_text("/%3A");
  endtask

  // Empty, dot and dot-dot segments, in the middle and at the end.
  task automatic test_dot_segments();
    set_idling(8, 8);
    send_text("/.");
    send_text("/..");
    send_text("/...");
    send_text("/.a");
    send_text("/a/./b");
    send_text("/a/../b");
    send_text("/a//b");
    send_text("/a/");
    send_text("/%2e%2E");
    send_text("/abcd/xy");
  endtask

  // Bulk of the run: mostly well-formed random paths, in each idling phase.
  task automatic test_random_paths();
    int phase_end;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_idling(0, 0);
        1:       set_idling(50, 0);
        2:       set_idling(0, 50);
        default: set_idling(8, 8);
      endcase
      phase_end = sent_bytes + 200;
      while (sent_bytes < phase_end) begin
        build_path();
        send_path();
      end
    end
  endtask

  // Short paths of arbitrary bytes, half of them led by a slash.
  task automatic test_noise_paths();
    int len;
    set_idling(8, 8);
    for (int n = 0; n < 25; n++) begin
      len = $urandom_range(1, 6);
      path_q.delete();
      for (int i = 0; i < len; i++) path_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(1) != 0) path_q[0] = ChSlash;
      send_path();
    end
  endtask

  initial begin
    int waited;
    clear_path_state();
    repeat (5) @(posedge clk_i);
    @(posedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_paths();
    test_escapes();
    test_forbidden_bytes();
    test_dot_segments();
    test_random_paths();
    test_noise_paths();

    // Drain: wait for owed results, then keep watching for anything extra.
    in_valid_i <= 1'b0;
    set_idling(0, 0);
    waited = 0;
    while (decoded_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      fail_cnt++;
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
